FILE: hdl/multi_key_record_sorter_assert.svh
// Assertion macros shared by the record sorter RTL.
// Clock i_clk and active-low reset i_rst_n must be in scope at the use site.
`ifndef MULTI_KEY_RECORD_SORTER_ASSERT_SVH
`define MULTI_KEY_RECORD_SORTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MKRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MKRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/mkrs_pkg.sv
// Package for the multi-key record sorter: capacity, beat and cell types,
// and the ordering compare. No dependencies.
`default_nettype none

package mkrs_pkg;

    localparam int MAX_RECORDS = 16;

    typedef struct packed {
        logic signed [7:0] first_key;
        logic signed [7:0] second_key;
        logic        [7:0] text_length;
        logic        [7:0] payload_tag;
        logic              final_record;
    } t_in_beat;

    typedef struct packed {
        logic signed [7:0] out_first_key;
        logic signed [7:0] out_second_key;
        logic        [7:0] out_text_length;
        logic        [7:0] out_payload_tag;
        logic              out_last;
        logic              overflow;
    } t_out_beat;

    typedef struct packed {
        logic signed [7:0] first_key;
        logic signed [7:0] second_key;
        logic        [7:0] text_length;
        logic        [7:0] payload_tag;
    } t_rec;

    typedef struct packed {
        logic valid;
        t_rec rec;
    } t_slot;

    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    // Strict lexicographic compare: first key and second key (both signed), then length.
    function automatic logic key_less(input t_rec a, input t_rec b);
        logic [23:0] ka;
        logic [23:0] kb;
        ka = {~a.first_key[7], a.first_key[6:0], ~a.second_key[7], a.second_key[6:0],
              a.text_length};
        kb = {~b.first_key[7], b.first_key[6:0], ~b.second_key[7], b.second_key[6:0],
              b.text_length};
        return ka < kb;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/mkrs_cell.sv
// One sorting cell: holds a single record and its valid bit.
// Depends on mkrs_pkg for record types and the ordering compare.
`default_nettype none

module mkrs_cell
    import mkrs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_rec      i_new_rec,
    input  wire logic      i_left_ins,
    input  wire t_slot     i_left_slot,
    input  wire t_slot     i_right_slot,
    output      t_slot     o_slot,
    output      logic      o_ins
);

    t_slot r_slot;
    t_slot n_slot;

    // The new record goes ahead of this entry only if strictly smaller: ties stay stable.
    assign o_ins  = !r_slot.valid || key_less(i_new_rec, r_slot.rec);
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.load) begin
            if (i_left_ins) begin
                n_slot = i_left_slot;
            end else if (o_ins) begin
                n_slot.valid = 1'b1;
                n_slot.rec   = i_new_rec;
            end
        end else if (i_ctl.shift) begin
            n_slot = i_right_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot <= n_slot;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/multi_key_record_sorter.sv
// Latency: after the final record's beat is accepted, the first sorted record is valid
// in the next cycle; results then leave at one per cycle while the output is not stalled.
// Throughput: records load at one per cycle into a chain of MAX_RECORDS insertion cells;
// a set of records is fully loaded and then fully emitted before the next set is taken.
// Input is stalled while a sorted run drains. Reset empties every cell and clears
// the overflow flag.
`default_nettype none

module multi_key_record_sorter
    import mkrs_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output      logic      o_in_stall,
    input  wire t_in_beat  i_in_data,
    output      logic      o_out_valid,
    input  wire logic      i_out_stall,
    output      t_out_beat o_out_data
);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_dropped;
    logic   n_dropped;

    t_rec      w_new_rec;
    t_cell_ctl w_ctl;
    t_slot     w_slot      [MAX_RECORDS];
    t_slot     w_left_slot [MAX_RECORDS];
    t_slot     w_right_slot[MAX_RECORDS];
    logic      w_ins       [MAX_RECORDS];
    logic      w_left_ins  [MAX_RECORDS];
    logic [MAX_RECORDS-1:0] w_valid;

    logic w_in_acc;
    logic w_out_acc;
    logic w_full;
    logic w_last;

    assign w_new_rec.first_key   = i_in_data.first_key;
    assign w_new_rec.second_key  = i_in_data.second_key;
    assign w_new_rec.text_length = i_in_data.text_length;
    assign w_new_rec.payload_tag = i_in_data.payload_tag;

    assign o_in_stall  = (r_state != ST_LOAD);
    assign o_out_valid = (r_state == ST_EMIT);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = o_out_valid && !i_out_stall;
    assign w_full      = w_slot[MAX_RECORDS-1].valid;
    assign w_last      = !w_slot[1].valid;

    // Drop the record when every cell is occupied.
    assign w_ctl.load  = w_in_acc && !w_full;
    assign w_ctl.shift = w_out_acc;

    always_comb begin
        for (int i = 0; i < MAX_RECORDS; i++) begin
            w_valid[i] = w_slot[i].valid;
            if (i == 0) begin
                w_left_slot[i] = '0;
                w_left_ins[i]  = 1'b0;
            end else begin
                w_left_slot[i] = w_slot[i-1];
                w_left_ins[i]  = w_ins[i-1];
            end
            if (i == MAX_RECORDS - 1) begin
                w_right_slot[i] = '0;
            end else begin
                w_right_slot[i] = w_slot[i+1];
            end
        end
    end

    for (genvar g = 0; g < MAX_RECORDS; g++) begin : g_cell
        mkrs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_new_rec    (w_new_rec),
            .i_left_ins   (w_left_ins[g]),
            .i_left_slot  (w_left_slot[g]),
            .i_right_slot (w_right_slot[g]),
            .o_slot       (w_slot[g]),
            .o_ins        (w_ins[g])
        );
    end

    assign o_out_data.out_first_key   = w_slot[0].rec.first_key;
    assign o_out_data.out_second_key  = w_slot[0].rec.second_key;
    assign o_out_data.out_text_length = w_slot[0].rec.text_length;
    assign o_out_data.out_payload_tag = w_slot[0].rec.payload_tag;
    assign o_out_data.out_last        = w_last;
    assign o_out_data.overflow        = r_dropped;

    always_comb begin
        n_state   = r_state;
        n_dropped = r_dropped;
        unique case (r_state)
            ST_LOAD: begin
                if (w_in_acc) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end
                    if (i_in_data.final_record) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (w_out_acc && w_last) begin
                    n_state   = ST_LOAD;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_dropped <= n_dropped;
        end
    end

`include "multi_key_record_sorter_assert.svh"

    `MKRS_ASSERT_IMP(a_valid_prefix, 1'b1, (w_valid & (w_valid + MAX_RECORDS'(1))) == '0, "cell valid bits are not a contiguous prefix")
    `MKRS_ASSERT_IMP(a_head_order, w_slot[1].valid, !key_less(w_slot[1].rec, w_slot[0].rec), "first two cells out of order")
    `MKRS_ASSERT_NXT(a_last_ends_run, w_out_acc && w_last, r_state == ST_LOAD && w_valid == '0, "run did not end empty after last beat")
    `MKRS_ASSERT_NXT(a_drop_flags, w_in_acc && w_full, r_dropped, "dropped record not flagged")

endmodule

`default_nettype wire
